// File: hdl/line_segment_clipper_unit_defines.svh
// Assertion macros for the line segment clipper.
`ifndef LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH
// assert that a implies b on the next cycle
`define LSC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("lsc check failed");
// assert that a implies b in the same cycle
`define LSC_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("lsc check failed");
`endif

// File: hdl/lsc_pkg.sv
// Shared codes for the line segment clipper.
package lsc_pkg;
  localparam logic [3:0] CodeLeft   = 4'd1;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeTop    = 4'd8;
  localparam logic [1:0] RegLeft    = 2'd0;
  localparam logic [1:0] RegBottom  = 2'd1;
  localparam logic [1:0] RegRight   = 2'd2;
  localparam logic [1:0] RegTop     = 2'd3;
endpackage

// File: hdl/line_segment_clipper_unit.sv
// Cohen-Sutherland line clipper top level with a bit-serial multiply/divide unit.
//
// One segment is taken per transfer and one result is returned. Each clipping
// pass multiplies with a bit-serial shift-add loop and divides with a restoring
// divider that produces one quotient bit per cycle. A pass also holds the
// outcode test and the endpoint update. A segment takes up to MAX_PASSES
// passes; a trivial accept or reject needs no pass. The block works on one
// segment at a time; the result register holds a finished result while it
// waits to be taken. Window registers are written through a plain write port,
// index 0..3 = left, bottom, right, top.
module line_segment_clipper_unit
  import lsc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_PASSES  = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: ax, ay, bx, by from the lowest bit up
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: visible, clip_ax, clip_ay, clip_bx, clip_by from the lowest bit up
  output logic [((4*COORD_WIDTH+8)/8)*8-1:0] m_axis_tdata
);
  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 2;          // differences
  localparam int PW  = 2 * EW;         // product magnitude
  localparam int CW  = $clog2(PW + 1);
  localparam int MPW = $clog2(MAX_PASSES + 1);
  localparam int OW  = ((4*W+8)/8)*8;

  localparam logic [2:0] StIdle = 3'd0, StTest = 3'd1, StMul = 3'd2,
                         StDiv = 3'd3, StFix = 3'd4, StOut = 3'd5;

  logic signed [W-1:0] wl_q, wb_q, wr_q, wt_q;
  logic [2:0] st_q;
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [MPW-1:0] moves_q;
  logic ok_q;
  logic [EW-1:0] ma_q, mb_q, md_q;    // magnitudes
  logic neg_q, vert_q, sel1_q;
  logic signed [W-1:0] edge_q;
  logic [PW-1:0] prod_q;
  logic [EW:0] rem_q;
  logic [PW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic out_v_q;
  logic [OW-1:0] out_q;

  // window writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= W'(100); wb_q <= W'(100); wr_q <= W'(300); wt_q <= W'(300);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLeft:   wl_q <= cfg_data_i;
        RegBottom: wb_q <= cfg_data_i;
        RegRight:  wr_q <= cfg_data_i;
        RegTop:    wt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] oc(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                    logic signed [W-1:0] l, logic signed [W-1:0] b,
                                    logic signed [W-1:0] r, logic signed [W-1:0] t);
    logic [3:0] c;
    c = 4'd0;
    if (x < l) c = c | CodeLeft;
    if (x > r) c = c | CodeRight;
    if (y < b) c = c | CodeBottom;
    if (y > t) c = c | CodeTop;
    return c;
  endfunction

  logic [3:0] c1, c2, o;
  logic signed [EW-1:0] dx, dy, dsel, dnum, dother;
  logic signed [W-1:0] edg;
  logic vsel;
  always_comb begin
    c1 = oc(x1_q, y1_q, wl_q, wb_q, wr_q, wt_q);
    c2 = oc(x2_q, y2_q, wl_q, wb_q, wr_q, wt_q);
    o  = (c1 != 4'd0) ? c1 : c2;
    dx = EW'(x2_q) - EW'(x1_q);
    dy = EW'(y2_q) - EW'(y1_q);
    vsel = (o & (CodeTop | CodeBottom)) != 4'd0;
    if (vsel) edg = ((o & CodeTop) != 4'd0) ? wt_q : wb_q;
    else      edg = ((o & CodeRight) != 4'd0) ? wr_q : wl_q;
    dsel   = vsel ? dy : dx;
    dother = vsel ? dx : dy;
    dnum   = EW'(edg) - (vsel ? EW'(y1_q) : EW'(x1_q));
  end

  // division trial
  logic [EW:0] rsh, rsub;
  always_comb begin
    rsh  = {rem_q[EW-1:0], prod_q[PW-1]};
    rsub = rsh - {1'b0, md_q};
  end

  logic signed [EW-1:0] qs;
  logic signed [W-1:0] newc;
  always_comb begin
    qs   = neg_q ? -EW'(quo_q[EW-1:0]) : EW'(quo_q[EW-1:0]);
    newc = W'((vert_q ? EW'(x1_q) : EW'(y1_q)) + qs);
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_v_q <= 1'b0;
      moves_q <= '0;
      cnt_q <= '0;
    end else begin
      // result register: load when free or being taken, else clear on transfer
      if (st_q == StOut && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      case (st_q)
        StIdle: if (s_axis_tvalid) begin
          x1_q <= s_axis_tdata[W-1:0];
          y1_q <= s_axis_tdata[2*W-1:W];
          x2_q <= s_axis_tdata[3*W-1:2*W];
          y2_q <= s_axis_tdata[4*W-1:3*W];
          moves_q <= '0;
          st_q <= StTest;
        end
        StTest: begin
          if (c1 == 4'd0 && c2 == 4'd0) begin
            ok_q <= 1'b1; st_q <= StOut;
          end else if ((c1 & c2) != 4'd0 || moves_q >= MPW'(MAX_PASSES) ||
                       dsel == '0) begin
            ok_q <= 1'b0; st_q <= StOut;
          end else begin
            moves_q <= moves_q + 1'b1;
            ma_q <= dother[EW-1] ? EW'(-dother) : dother;
            mb_q <= dnum[EW-1] ? EW'(-dnum) : dnum;
            md_q <= dsel[EW-1] ? EW'(-dsel) : dsel;
            neg_q <= dother[EW-1] ^ dnum[EW-1] ^ dsel[EW-1];
            vert_q <= vsel;
            sel1_q <= (c1 != 4'd0);
            edge_q <= edg;
            prod_q <= '0;
            cnt_q <= '0;
            st_q <= StMul;
          end
        end
        StMul: begin
          // one multiplier bit a cycle, LSB first
          if (cnt_q == CW'(EW)) begin
            cnt_q <= '0; rem_q <= '0; quo_q <= '0;
            st_q <= StDiv;
          end else begin
            if (mb_q[0]) prod_q <= prod_q + (PW'(ma_q) << cnt_q);
            mb_q <= mb_q >> 1;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StDiv: begin
          // one quotient bit a cycle, restoring
          if (!rsub[EW]) rem_q <= rsub; else rem_q <= rsh;
          quo_q <= {quo_q[PW-2:0], ~rsub[EW]};
          prod_q <= prod_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(PW-1)) st_q <= StFix;
        end
        StFix: begin
          if (sel1_q) begin
            if (vert_q) begin x1_q <= newc; y1_q <= edge_q; end
            else begin x1_q <= edge_q; y1_q <= newc; end
          end else begin
            if (vert_q) begin x2_q <= newc; y2_q <= edge_q; end
            else begin x2_q <= edge_q; y2_q <= newc; end
          end
          st_q <= StTest;
        end
        StOut: if (!out_v_q || m_axis_tready) begin
          out_q <= ok_q ? OW'({y2_q, x2_q, y1_q, x1_q, 1'b1}) : '0;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  `include "line_segment_clipper_unit_defines.svh"

  // a taken segment always goes to the outcode test first
  `LSC_ASSERT_NEXT(a_take_test, s_axis_tvalid && s_axis_tready, st_q == StTest)
  // passes never exceed the limit
  `LSC_ASSERT_NOW(a_pass_lim, st_q == StMul, moves_q <= MPW'(MAX_PASSES))
  // a held result is not overwritten
  `LSC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
